// File: hw/rtl/aupd_pkg.sv
package aupd_pkg;

  // Field widths
  localparam int unsigned IdxW    = 12;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgIdxW = 2;

  // 1.0 in unsigned Q1.32
  localparam logic [32:0] OneQ32 = 33'h1_0000_0000;

  // Register reset values
  localparam logic [31:0] LearnRateRst  = 32'd16777;
  localparam logic [31:0] BetaFirstRst  = 32'd3865470566;
  localparam logic [31:0] BetaSecondRst = 32'd4290672329;
  localparam logic [31:0] EpsTermRst    = 32'd1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegLearnRate  = 2'd0,
    RegBetaFirst  = 2'd1,
    RegBetaSecond = 2'd2,
    RegEpsTerm    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] learn_rate;
    logic [31:0] beta_first;
    logic [31:0] beta_second;
    logic [31:0] eps_term;
  } cfg_t;

  // Moment unit result: new moments plus bias-correction denominators
  typedef struct packed {
    logic signed [31:0] param;
    logic signed [31:0] m_new;
    logic [63:0]        v_new;
    logic [32:0]        d1;
    logic [32:0]        d2;
  } mom_res_t;

  // Sideband through the v_hat divider
  typedef struct packed {
    logic signed [31:0] param;
    logic               neg;
    logic [63:0]        prod;
    logic [32:0]        d1;
    logic               vovf;
  } side_vdiv_t;

  // Sideband through the square root
  typedef struct packed {
    logic signed [31:0] param;
    logic               neg;
    logic [63:0]        prod;
    logic [32:0]        d1;
  } side_sqrt_t;

  // Sideband through the update divider
  typedef struct packed {
    logic signed [31:0] param;
    logic               neg;
    logic               uovf;
  } side_udiv_t;

  // 1 - power in Q1.32, a zero denominator taken as one ulp
  function automatic logic [32:0] bias_denom(logic [32:0] pw);
    logic [32:0] d;
    d = OneQ32 - pw;
    return (d == '0) ? 33'd1 : d;
  endfunction

endpackage

// File: hw/rtl/aupd_if.sv
interface aupd_in_if import aupd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IdxW-1:0]         elem_index;
  logic signed [DataW-1:0] param_value;
  logic signed [DataW-1:0] grad_value;

  modport source (output valid, elem_index, param_value, grad_value, input ready);
  modport sink   (input valid, elem_index, param_value, grad_value, output ready);
endinterface

interface aupd_out_if import aupd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] new_param;
  logic                    saturated;

  modport source (output valid, new_param, saturated, input ready);
  modport sink   (input valid, new_param, saturated, output ready);
endinterface

interface aupd_cfg_if import aupd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/adam_parameter_update_unit.sv
// Adam update of one tensor element per item: new_param = param - lr * m_hat /
// (sqrt(v_hat) + eps), with per-index moments in an on-chip store and running beta
// powers; an item with index zero opens a new step. One item per cycle is accepted
// while the output is not held and no index hazard stalls stage A; items pass the two
// bit-per-stage dividers (64 and 34 stages) and the 32-stage square root. An item
// whose index matches one still in stage B or C is held in stage A, since the moment
// read-modify-write spans stages B and C. After reset a clearing pass zeroes the
// moment store; no item is accepted during it, configuration writes are. Results
// saturate to Q8.24 and raise saturated when clipped.
module adam_parameter_update_unit import aupd_pkg::*; #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aupd_in_if.sink   in_i,
  aupd_out_if.source out_o,
  aupd_cfg_if.sink  cfg_i
);

  localparam logic [33:0] UCap = 34'h2_0000_0000;

  cfg_t cfg_q;

  logic     adv;
  logic     mom_clr, mom_vld;
  mom_res_t mom_res;

  // stage D
  logic     d_vld_q;
  mom_res_t d_res_q;
  logic [31:0] am;

  // stage E
  logic               e_vld_q;
  logic signed [31:0] e_par_q;
  logic               e_neg_q, e_ovf_q;
  logic [63:0]        e_prod_q, e_v_q;
  logic [32:0]        e_d1_q, e_d2_q;
  side_vdiv_t         e_side;

  // v_hat divider
  logic        vd_vld;
  logic [63:0] vd_quo;
  side_vdiv_t  vd_side;
  logic [63:0] vhat;
  side_sqrt_t  sq_side_in;

  // square root
  logic        sq_vld;
  logic [31:0] sq_root;
  side_sqrt_t  sq_side;
  logic [32:0] s_sum;

  // stages F, G, H
  logic        f_vld_q;
  logic [32:0] f_s_q;
  side_sqrt_t  f_side_q;
  logic        g_vld_q;
  logic [65:0] g_dd_q;
  side_sqrt_t  g_side_q;
  logic        h_vld_q;
  logic [65:0] h_rem_q, h_dd_q;
  logic [33:0] h_num_q;
  side_udiv_t  h_side_q;

  // update divider and output
  logic        ud_vld;
  logic [33:0] ud_quo;
  side_udiv_t  ud_side;
  logic [33:0] u_mag;
  logic signed [35:0] res_ext;
  logic        sat_hi, sat_lo;
  logic        out_vld_q, out_sat_q, out_load;
  logic signed [31:0] out_par_q;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_rate  <= LearnRateRst;
      cfg_q.beta_first  <= BetaFirstRst;
      cfg_q.beta_second <= BetaSecondRst;
      cfg_q.eps_term    <= EpsTermRst;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        RegLearnRate:  cfg_q.learn_rate  <= cfg_i.data;
        RegBetaFirst:  cfg_q.beta_first  <= cfg_i.data;
        RegBetaSecond: cfg_q.beta_second <= cfg_i.data;
        RegEpsTerm:    cfg_q.eps_term    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline moves unless a finished item would land on a held result
  assign adv = !out_vld_q || out_o.ready || !ud_vld;

  aupd_moment #(.DEPTH(DEPTH)) u_moment (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .elem_index_i  (in_i.elem_index),
    .param_value_i (in_i.param_value),
    .grad_value_i  (in_i.grad_value),
    .clr_o         (mom_clr),
    .res_vld_o     (mom_vld),
    .res_o         (mom_res)
  );

  // valid bits of the local stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
    end else if (adv) begin
      d_vld_q <= mom_vld;
      e_vld_q <= d_vld_q;
      f_vld_q <= sq_vld;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
    end
  end

  // D: register moments; E: |m| * lr and v_hat overflow check
  assign am = d_res_q.m_new[31] ? (~d_res_q.m_new[31:0] + 32'd1) : d_res_q.m_new[31:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_res_q  <= mom_res;
      e_par_q  <= d_res_q.param;
      e_neg_q  <= d_res_q.m_new[31];
      e_prod_q <= 64'(cfg_q.learn_rate) * 64'(am);
      e_v_q    <= d_res_q.v_new;
      e_d1_q   <= d_res_q.d1;
      e_d2_q   <= d_res_q.d2;
      e_ovf_q  <= (33'(d_res_q.v_new[63:32]) >= d_res_q.d2);
    end
  end

  assign e_side.param = e_par_q;
  assign e_side.neg   = e_neg_q;
  assign e_side.prod  = e_prod_q;
  assign e_side.d1    = e_d1_q;
  assign e_side.vovf  = e_ovf_q;

  // v_hat = v * 2^32 / d2
  aupd_div_pipe #(.DW(33), .QW(64), .SW($bits(side_vdiv_t))) u_vdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (e_vld_q),
    .rem_i  ({1'b0, e_v_q[63:32]}),
    .num_i  ({e_v_q[31:0], 32'd0}),
    .div_i  (e_d2_q),
    .side_i (e_side),
    .vld_o  (vd_vld),
    .quo_o  (vd_quo),
    .side_o (vd_side)
  );

  assign vhat             = vd_side.vovf ? '1 : vd_quo;
  assign sq_side_in.param = vd_side.param;
  assign sq_side_in.neg   = vd_side.neg;
  assign sq_side_in.prod  = vd_side.prod;
  assign sq_side_in.d1    = vd_side.d1;

  aupd_isqrt_pipe #(.SW($bits(side_sqrt_t))) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vd_vld),
    .rad_i  (vhat),
    .side_i (sq_side_in),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // F: denominator S; G: d1 * S; H: overflow check of the final quotient
  assign s_sum = 33'(sq_root) + 33'(cfg_q.eps_term);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_s_q          <= (s_sum == '0) ? 33'd1 : s_sum;
      f_side_q       <= sq_side;
      g_dd_q         <= 66'(f_side_q.d1) * 66'(f_s_q);
      g_side_q       <= f_side_q;
      h_rem_q        <= 66'(g_side_q.prod[63:2]);
      h_num_q        <= {g_side_q.prod[1:0], 32'd0};
      h_dd_q         <= g_dd_q;
      h_side_q.param <= g_side_q.param;
      h_side_q.neg   <= g_side_q.neg;
      h_side_q.uovf  <= (66'(g_side_q.prod[63:2]) >= g_dd_q);
    end
  end

  // U = lr * |m| * 2^32 / (d1 * S)
  aupd_div_pipe #(.DW(66), .QW(34), .SW($bits(side_udiv_t))) u_udiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (h_vld_q),
    .rem_i  (h_rem_q),
    .num_i  (h_num_q),
    .div_i  (h_dd_q),
    .side_i (h_side_q),
    .vld_o  (ud_vld),
    .quo_o  (ud_quo),
    .side_o (ud_side)
  );

  // cap, apply and saturate
  assign u_mag   = (ud_side.uovf || (ud_quo > UCap)) ? UCap : ud_quo;
  assign res_ext = ud_side.neg ? (36'(ud_side.param) + $signed({2'b00, u_mag}))
                               : (36'(ud_side.param) - $signed({2'b00, u_mag}));
  assign sat_hi  = !res_ext[35] && (res_ext[34:31] != 4'h0);
  assign sat_lo  = res_ext[35] && (res_ext[34:31] != 4'hF);

  assign out_load = adv && ud_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_par_q <= sat_hi ? 32'sh7FFF_FFFF : (sat_lo ? 32'sh8000_0000 : res_ext[31:0]);
      out_sat_q <= sat_hi || sat_lo;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.new_param = out_par_q;
  assign out_o.saturated = out_sat_q;

  // no item enters while the store is being cleared
  a_clr_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mom_clr |-> !in_i.ready)
    else $error("item accepted during store clearing");

  // a clipped result sits on a range limit
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.saturated) |->
      (out_o.new_param == 32'sh7FFF_FFFF || out_o.new_param == 32'sh8000_0000))
    else $error("saturated result not at a range limit");

  // a finished item is never dropped onto a held result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready && ud_vld) |=> $stable(out_par_q))
    else $error("held result overwritten");

endmodule

// File: hw/rtl/aupd_div_pipe.sv
// Restoring divider, one quotient bit per register stage.
// rem_i must be below div_i; num_i holds the dividend bits still to shift in.
module aupd_div_pipe #(
  parameter int unsigned DW = 33,
  parameter int unsigned QW = 64,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] sh_q   [QW];
  logic [DW-1:0] dv_q   [QW];
  logic [SW-1:0] sd_q   [QW];
  logic [QW-1:0] vld_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] sh_in;
    logic [DW-1:0] dv_in;
    logic [SW-1:0] sd_in;
    logic          vld_in;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign sh_in  = num_i;
      assign dv_in  = div_i;
      assign sd_in  = side_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign sh_in  = sh_q[k-1];
      assign dv_in  = dv_q[k-1];
      assign sd_in  = sd_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    // shift in next dividend bit, subtract where it fits
    assign trial = {rem_in, sh_in[QW-1]};
    assign take  = (trial >= {1'b0, dv_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? DW'(trial - {1'b0, dv_in}) : trial[DW-1:0];
        sh_q[k]  <= {sh_in[QW-2:0], take};
        dv_q[k]  <= dv_in;
        sd_q[k]  <= sd_in;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = sh_q[QW-1];
  assign side_o = sd_q[QW-1];

endmodule

// File: hw/rtl/aupd_isqrt_pipe.sv
// Integer square root of a 64-bit value, one result bit per register stage.
module aupd_isqrt_pipe #(
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [63:0]   rad_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [31:0]   root_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned NumStg = 32;

  logic [63:0]   x_q   [NumStg];
  logic [63:0]   res_q [NumStg];
  logic [SW-1:0] sd_q  [NumStg];
  logic [NumStg-1:0] vld_q;

  for (genvar k = 0; k < NumStg; k++) begin : g_stage
    localparam logic [63:0] BitK = 64'd1 << (62 - 2 * k);
    logic [63:0]   x_in;
    logic [63:0]   res_in;
    logic [SW-1:0] sd_in;
    logic          vld_in;
    logic [63:0]   tsum;
    logic          ge;

    if (k == 0) begin : g_first
      assign x_in   = rad_i;
      assign res_in = '0;
      assign sd_in  = side_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign x_in   = x_q[k-1];
      assign res_in = res_q[k-1];
      assign sd_in  = sd_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    assign tsum = res_in + BitK;
    assign ge   = (x_in >= tsum);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]   <= ge ? (x_in - tsum) : x_in;
        res_q[k] <= ge ? ((res_in >> 1) + BitK) : (res_in >> 1);
        sd_q[k]  <= sd_in;
      end
    end
  end

  assign vld_o  = vld_q[NumStg-1];
  assign root_o = res_q[NumStg-1][31:0];
  assign side_o = sd_q[NumStg-1];

endmodule

// File: hw/rtl/aupd_moment.sv
// Moment store and update: input stage, store read, products, sums and write-back.
module aupd_moment import aupd_pkg::*; #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [IdxW-1:0]         elem_index_i,
  input  logic signed [DataW-1:0] param_value_i,
  input  logic signed [DataW-1:0] grad_value_i,
  output logic                    clr_o,
  output logic                    res_vld_o,
  output mom_res_t                res_o
);

  localparam int unsigned AddrW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [31:0] DepthVal = 32'(DEPTH);

  // index modulo DEPTH by conditional subtraction
  function automatic logic [AddrW-1:0] wrap_idx(logic [IdxW-1:0] raw);
    logic [31:0] r;
    r = 32'(raw);
    for (int k = IdxW - 1; k >= 0; k--) begin
      if (r >= (DepthVal << k)) begin
        r = r - (DepthVal << k);
      end
    end
    return r[AddrW-1:0];
  endfunction

  // moment store
  logic signed [31:0] m_mem [DEPTH];
  logic [63:0]        v_mem [DEPTH];

  // clearing pass
  logic             clr_q;
  logic [AddrW-1:0] cnt_q;

  // running powers of the betas
  logic [32:0] pw1_q, pw2_q;
  logic [64:0] pw1_prod, pw2_prod;
  logic [32:0] pw1_nx, pw2_nx, pw1_use, pw2_use;
  logic        idx_zero, in_acc;

  // stage A: accepted item
  logic               a_vld_q;
  logic [AddrW-1:0]   a_idx_q;
  logic signed [31:0] a_par_q, a_grad_q;
  logic [32:0]        a_pw1_q, a_pw2_q;
  logic               haz, a_go;

  // stage B: store read data
  logic               b_vld_q;
  logic [AddrW-1:0]   b_idx_q;
  logic signed [31:0] b_par_q, b_grad_q;
  logic [63:0]        b_g2_q;
  logic [32:0]        b_d1_q, b_d2_q;
  logic signed [31:0] b_m_q;
  logic [63:0]        b_v_q;
  logic [31:0]        ag;

  // stage C: products
  logic               c_vld_q;
  logic [AddrW-1:0]   c_idx_q;
  logic signed [31:0] c_par_q;
  logic [32:0]        c_d1_q, c_d2_q;
  logic signed [65:0] c_pm1_q, c_pm2_q;
  logic [63:0]        c_p0a_q, c_p1a_q;
  logic [64:0]        c_p0b_q, c_p1b_q;
  logic [32:0]        nb1, nb2;

  // stage C sums
  logic signed [65:0] m_sum;
  logic signed [31:0] m_new;
  logic [63:0]        h1, h2, v_new;
  logic [32:0]        fsum;

  // power step on an item that opens a new step
  assign idx_zero = (elem_index_i == '0);
  assign pw1_prod = 65'(pw1_q) * 65'(cfg_i.beta_first);
  assign pw2_prod = 65'(pw2_q) * 65'(cfg_i.beta_second);
  assign pw1_nx   = pw1_prod[64:32];
  assign pw2_nx   = pw2_prod[64:32];
  assign pw1_use  = idx_zero ? pw1_nx : pw1_q;
  assign pw2_use  = idx_zero ? pw2_nx : pw2_q;

  // same index still in read-modify-write holds stage A
  assign haz  = (b_vld_q && (b_idx_q == a_idx_q)) || (c_vld_q && (c_idx_q == a_idx_q));
  assign a_go = a_vld_q && !haz;

  assign in_ready_o = en_i && !clr_q && (!a_vld_q || !haz);
  assign in_acc     = in_valid_i && in_ready_o;
  assign clr_o      = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
    end else if (clr_q) begin
      cnt_q <= cnt_q + AddrW'(1);
      if (cnt_q == AddrW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw1_q <= OneQ32;
      pw2_q <= OneQ32;
    end else if (in_acc && idx_zero) begin
      pw1_q <= pw1_nx;
      pw2_q <= pw2_nx;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= in_acc ? 1'b1 : (a_go ? 1'b0 : a_vld_q);
      b_vld_q <= a_go;
      c_vld_q <= b_vld_q;
    end
  end

  // stage A payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_idx_q  <= wrap_idx(elem_index_i);
      a_par_q  <= param_value_i;
      a_grad_q <= grad_value_i;
      a_pw1_q  <= pw1_use;
      a_pw2_q  <= pw2_use;
    end
  end

  // stage B payload
  assign ag = a_grad_q[31] ? (~a_grad_q[31:0] + 32'd1) : a_grad_q[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_idx_q  <= a_idx_q;
      b_par_q  <= a_par_q;
      b_grad_q <= a_grad_q;
      b_g2_q   <= 64'(ag) * 64'(ag);
      b_d1_q   <= bias_denom(a_pw1_q);
      b_d2_q   <= bias_denom(a_pw2_q);
    end
  end

  // stage C products
  assign nb1 = OneQ32 - {1'b0, cfg_i.beta_first};
  assign nb2 = OneQ32 - {1'b0, cfg_i.beta_second};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_idx_q <= b_idx_q;
      c_par_q <= b_par_q;
      c_d1_q  <= b_d1_q;
      c_d2_q  <= b_d2_q;
      c_pm1_q <= 66'($signed({1'b0, cfg_i.beta_first})) * 66'(b_m_q);
      c_pm2_q <= 66'($signed({1'b0, nb1})) * 66'(b_grad_q);
      c_p0a_q <= 64'(b_v_q[31:0]) * 64'(cfg_i.beta_second);
      c_p1a_q <= 64'(b_v_q[63:32]) * 64'(cfg_i.beta_second);
      c_p0b_q <= 65'(b_g2_q[31:0]) * 65'(nb2);
      c_p1b_q <= 65'(b_g2_q[63:32]) * 65'(nb2);
    end
  end

  // weighted sums, floored
  assign m_sum = c_pm1_q + c_pm2_q;
  assign m_new = m_sum[63:32];
  assign h1    = 64'(c_p0a_q[63:32]) + c_p1a_q;
  assign h2    = 64'(c_p0b_q[64:32]) + c_p1b_q[63:0];
  assign fsum  = 33'(c_p0a_q[31:0]) + 33'(c_p0b_q[31:0]);
  assign v_new = h1 + h2 + 64'(fsum[32]);

  // store: clearing pass or write-back, read for stage B
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      m_mem[cnt_q] <= '0;
      v_mem[cnt_q] <= '0;
    end else if (en_i && c_vld_q) begin
      m_mem[c_idx_q] <= m_new;
      v_mem[c_idx_q] <= v_new;
    end
    if (en_i) begin
      b_m_q <= m_mem[a_idx_q];
      b_v_q <= v_mem[a_idx_q];
    end
  end

  assign res_vld_o   = c_vld_q;
  assign res_o.param = c_par_q;
  assign res_o.m_new = m_new;
  assign res_o.v_new = v_new;
  assign res_o.d1    = c_d1_q;
  assign res_o.d2    = c_d2_q;

endmodule
